/* rtl/usan_pkg.sv */
// Shared types, constants and UTF-8 checking functions for the stream sanitizer.
package usan_pkg;

  // Marker text characters and length
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [2:0] MARKER_LEN = 3'd6;

  // Request queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Verdict kinds of one scan position
  localparam logic [1:0] VK_HOLD = 2'd0;
  localparam logic [1:0] VK_FAIL = 2'd1;
  localparam logic [1:0] VK_EMIT = 2'd2;

  // Code point limits
  localparam logic [20:0] CP_MIN2    = 21'h00080;
  localparam logic [20:0] CP_MIN3    = 21'h00800;
  localparam logic [20:0] CP_MIN4    = 21'h10000;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] CP_SUR_LO  = 21'h0D800;
  localparam logic [20:0] CP_SUR_HI  = 21'h0DFFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] len;
  } verdict_t;

  // One request from the front to the back: a marker for bytes[0], or len bytes to pass
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            marker;
    logic            last;
    logic            str_end;
  } cmd_t;

  // Sequence length announced by a lead byte, zero if it cannot lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) len = 3'd1;
    else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  // Judge the n bytes at the head of p
  function automatic verdict_t judge(input logic [3:0][7:0] p, input logic [2:0] n,
                                     input logic at_end);
    logic [2:0]  len;
    logic [2:0]  have;
    logic        bad;
    logic [20:0] cp;
    verdict_t    v;
    len  = lead_len(p[0]);
    have = (n < len) ? n : len;
    bad  = ((have > 3'd1) && (p[1][7:6] != 2'b10)) ||
           ((have > 3'd2) && (p[2][7:6] != 2'b10)) ||
           ((have > 3'd3) && (p[3][7:6] != 2'b10));
    case (len)
      3'd2:    cp = {10'd0, p[0][4:0], p[1][5:0]};
      3'd3:    cp = {5'd0, p[0][3:0], p[1][5:0], p[2][5:0]};
      3'd4:    cp = {p[0][2:0], p[1][5:0], p[2][5:0], p[3][5:0]};
      default: cp = {13'd0, p[0]};
    endcase
    v.len = len;
    if ((len == 3'd0) || bad) begin
      v.kind = VK_FAIL;
    end else if (have < len) begin
      v.kind = at_end ? VK_FAIL : VK_HOLD;
    end else if (((len == 3'd2) && (cp < CP_MIN2)) ||
                 ((len == 3'd3) && (cp < CP_MIN3)) ||
                 ((len == 3'd4) && (cp < CP_MIN4)) ||
                 (cp > CP_MAX) ||
                 ((cp >= CP_SUR_LO) && (cp <= CP_SUR_HI))) begin
      v.kind = VK_FAIL;
    end else begin
      v.kind = VK_EMIT;
    end
    return v;
  endfunction

  // Uppercase hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h37 + {4'h0, d});
  endfunction

endpackage

/* rtl/usan_front.sv */
// Front end: accepts bytes, keeps unfinished sequences, scans and issues requests.
module usan_front import usan_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       string_end,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       q_full
);

  logic [2:0][7:0] win;
  logic [1:0]      wcnt;
  logic            wend;
  logic            busy;

  logic [3:0][7:0] cur;
  logic [2:0]      cn;
  logic            ce;
  logic            proc;
  verdict_t        v;
  logic [2:0]      k;
  logic [3:0][7:0] rem;
  logic [2:0]      rn;
  verdict_t        rv;
  logic            last;

  // Build the scan window: leftover bytes while busy, else held bytes plus the new one
  always_comb begin
    if (busy) begin
      cur = {8'h00, win[2], win[1], win[0]};
      cn  = {1'b0, wcnt};
      ce  = wend;
    end else begin
      cur[0] = (wcnt == 2'd0) ? in_byte : win[0];
      cur[1] = (wcnt == 2'd1) ? in_byte : ((wcnt > 2'd1) ? win[1] : 8'h00);
      cur[2] = (wcnt == 2'd2) ? in_byte : ((wcnt == 2'd3) ? win[2] : 8'h00);
      cur[3] = (wcnt == 2'd3) ? in_byte : 8'h00;
      cn     = {1'b0, wcnt} + 3'd1;
      ce     = string_end;
    end
  end

  assign in_ready = !busy && !q_full;
  assign proc     = !q_full && (busy || in_valid);

  // Judge the head, then look ahead at what is left to know if this request ends the run
  always_comb begin
    logic [3:0] sh;
    v  = judge(cur, cn, ce);
    k  = (v.kind == VK_FAIL) ? 3'd1 : v.len;
    for (int i = 0; i < 4; i++) begin
      sh     = 4'(i) + {1'b0, k};
      rem[i] = (sh < 4'd4) ? cur[sh[1:0]] : 8'h00;
    end
    rn   = cn - k;
    rv   = judge(rem, rn, ce);
    last = (rn == 3'd0) || (rv.kind == VK_HOLD);
  end

  // Issue a request unless the head only waits for more bytes
  assign push                  = proc && (v.kind != VK_HOLD);
  assign push_cmd.bytes        = cur;
  assign push_cmd.len          = v.len;
  assign push_cmd.marker       = (v.kind == VK_FAIL);
  assign push_cmd.last         = last;
  assign push_cmd.str_end      = ce && last;

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      wcnt <= 2'd0;
    end else if (proc) begin
      if (v.kind == VK_HOLD) begin
        busy <= 1'b0;
        wcnt <= cn[1:0];
      end else begin
        busy <= !last;
        wcnt <= rn[1:0];
      end
    end
  end

  // Hold bytes of the window
  always_ff @(posedge clk) begin
    if (proc) begin
      if (v.kind == VK_HOLD) begin
        win <= cur[2:0];
      end else begin
        win  <= rem[2:0];
        wend <= ce;
      end
    end
  end

endmodule

/* rtl/usan_fifo.sv */
// Short request queue between the front and back ends.
module usan_fifo import usan_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  assign head  = mem[rptr];
  assign empty = (count == '0);
  assign full  = (count == (QAW+1)'(QDEPTH));

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  // Store requests
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_cmd;
  end

endmodule

/* rtl/usan_back.sv */
// Back end: expands requests into output bytes through an output register.
module usan_back import usan_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  output logic [7:0] out_byte,
  output logic       out_string_end,
  output logic       run_last,
  output logic       is_marker,
  output logic       out_valid,
  input  logic       out_ready
);

  logic [2:0] idx;
  logic [2:0] cmd_n;
  logic       fin;
  logic       load;
  logic [7:0] sel_byte;

  assign cmd_n = head.marker ? MARKER_LEN : head.len;
  assign fin   = (idx == cmd_n - 3'd1);
  assign load  = !empty && (!out_valid || out_ready);
  assign pop   = load && fin;

  // Pick the byte at the current position of the request
  always_comb begin
    if (head.marker) begin
      case (idx)
        3'd0:    sel_byte = CH_LT;
        3'd1:    sel_byte = CH_ZERO;
        3'd2:    sel_byte = CH_X;
        3'd3:    sel_byte = hex_char(head.bytes[0][7:4]);
        3'd4:    sel_byte = hex_char(head.bytes[0][3:0]);
        default: sel_byte = CH_GT;
      endcase
    end else begin
      sel_byte = head.bytes[idx[1:0]];
    end
  end

  // Advance position and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= fin ? 3'd0 : idx + 3'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= sel_byte;
      is_marker      <= head.marker;
      run_last       <= head.last && fin;
      out_string_end <= head.str_end && fin;
    end
  end

endmodule

/* rtl/utf8_stream_sanitizer.sv */
// Top level of the UTF-8 stream sanitizer.
//
// Input channel (in_valid/in_ready): one raw byte per request, with string_end
// on the last byte of each string. Output channel (out_valid/out_ready): one
// sanitized byte per request, with out_string_end on the final byte of a string,
// run_last on the last byte caused by one input byte and is_marker on the bytes
// of a "<0xHH>" replacement marker.
// Throughput: one input byte per cycle while the queue has room and no rescan
// is pending, so clean ASCII runs at one byte per clock while the receiver is
// ready. A failing lead that forces a rescan of held bytes holds in_ready low
// while the front rescans, and a marker occupies the output for six bytes.
// A byte that completes a sequence is queued as a request; the back end loads
// its first output byte into the output register. Bytes of an unfinished
// sequence produce nothing until it completes, breaks or its string ends.
// The front end and back end are parted by a four-entry request queue; when the
// receiver stalls, the output register holds and the queue absorbs up to four
// requests before in_ready drops.
// Reset (rst, synchronous) empties the queue, drops held bytes and clears out_valid.
module utf8_stream_sanitizer import usan_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       string_end,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] out_byte,
  output logic       out_string_end,
  output logic       run_last,
  output logic       is_marker,
  output logic       out_valid,
  input  logic       out_ready
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic empty;
  logic full;

  usan_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .string_end (string_end),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (full)
  );

  usan_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  usan_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_string_end (out_string_end),
    .run_last       (run_last),
    .is_marker      (is_marker),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

endmodule

/* rtl/usan_checker.sv */
// Port-level checks for the UTF-8 stream sanitizer, bound to the top level.
module usan_checker import usan_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic [7:0] in_byte,
  input logic       string_end,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] out_byte,
  input logic       out_string_end,
  input logic       run_last,
  input logic       is_marker,
  input logic       out_valid,
  input logic       out_ready
);

  // Reset drops any pending output request
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A waiting input request holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(string_end))
    else $error("waiting input request changed");

  // A stalled output request holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_marker) &&
      $stable(run_last) && $stable(out_string_end))
    else $error("stalled output request changed");

  // A string only ends on the last byte of a run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_string_end |-> run_last)
    else $error("string end without run end");

  // The opening bracket of a marker never ends a run
  a_marker_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_marker && (out_byte == CH_LT) |-> !run_last && !out_string_end)
    else $error("marker cut after its opening bracket");

endmodule

bind utf8_stream_sanitizer usan_checker u_usan_checker (.*);
